FILE: hdl/lrurp_pkg.sv
`timescale 1ns / 1ps

package lrurp_pkg;

  // table geometry
  localparam int ENTRIES  = 16;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int RANK_W   = IDX_W;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int KEY_W    = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_ACCESS = 3'd1,
    OP_POP    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_PIN    = 3'd4,
    OP_UNPIN  = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

endpackage

FILE: hdl/lrurp_in_if.sv
`timescale 1ns / 1ps

interface lrurp_in_if;
  import lrurp_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [KEY_W-1:0]  key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

FILE: hdl/lrurp_out_if.sv
`timescale 1ns / 1ps

interface lrurp_out_if;
  import lrurp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [KEY_W-1:0]     victim_key;
  logic                 can_replace;
  logic [CNT_W-1:0]     unpinned_count;

  modport source (output valid, output status, output victim_key, output can_replace,
                  output unpinned_count, input ready);
  modport sink   (input valid, input status, input victim_key, input can_replace,
                  input unpinned_count, output ready);
endinterface

FILE: hdl/lru_replacer_with_pinning_unit.sv
`timescale 1ns / 1ps

// LRU replacement table with pinning, 16 register slots. Each item (op, key)
// gives exactly one result item (status, victim key, replace flag, unpinned
// count). An accepted item sits in an input register while all
// slots are compared against its key and the recency ranks are updated in
// parallel. The result is registered at the same edge that commits the new
// table state. So an item passes through the input register and then the
// result register before its result can be taken. One item is accepted
// every cycle as long as results are taken. The rate is set by the key
// compare and rank update, done combinationally across the slot registers.
// While a result waits, one more item can be accepted and is held in the
// input register.
module lru_replacer_with_pinning_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  lrurp_in_if.sink       in_i,
  lrurp_out_if.source    out_o
);
  import lrurp_pkg::*;

  // input register
  logic                in_vld_q;
  logic [OP_W-1:0]     op_q;
  logic [KEY_W-1:0]    ikey_q;

  // result register
  logic                out_vld_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [KEY_W-1:0]    victim_q, victim_d;

  // table state
  logic [KEY_W-1:0]    key_q   [ENTRIES];
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [ENTRIES-1:0]  pinned_q, pinned_d;
  logic [RANK_W-1:0]   rank_q  [ENTRIES];
  logic [RANK_W-1:0]   rank_d  [ENTRIES];
  logic [RANK_W-1:0]   rank_dec [ENTRIES];
  logic [CNT_W-1:0]    count_q, count_d;

  // slot search results
  logic [ENTRIES-1:0]  hit, free_v, lru_v, in_order;
  logic [IDX_W-1:0]    hit_idx, free_idx, lru_idx, sel_idx;
  logic                hit_any, free_any, lru_any;
  logic                key_we;

  logic                out_free, adv;

  assign out_free = !out_vld_q || out_o.ready;
  assign adv      = in_vld_q && out_free;

  assign in_i.ready = !in_vld_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q   <= in_i.op;
      ikey_q <= in_i.key;
    end
  end

  // parallel compare against every slot
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i]      = valid_q[i] && (key_q[i] == ikey_q);
      free_v[i]   = !valid_q[i];
      in_order[i] = valid_q[i] && !pinned_q[i];
      lru_v[i]    = in_order[i] && (rank_q[i] == '0);
    end
    hit_any  = |hit;
    free_any = |free_v;
    lru_any  = |lru_v;
  end

  // lowest matching slot for each search
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    lru_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit[i])    hit_idx  = IDX_W'(i);
      if (free_v[i]) free_idx = IDX_W'(i);
      if (lru_v[i])  lru_idx  = IDX_W'(i);
    end
  end

  // ranks after the selected slot leaves the order
  assign sel_idx = (op_q == OP_POP) ? lru_idx : hit_idx;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (in_order[i] && (IDX_W'(i) != sel_idx) && (rank_q[i] > rank_q[sel_idx])) begin
        rank_dec[i] = rank_q[i] - RANK_W'(1);
      end else begin
        rank_dec[i] = rank_q[i];
      end
    end
  end

  // operation decode and next state
  always_comb begin
    valid_d  = valid_q;
    pinned_d = pinned_q;
    rank_d   = rank_q;
    count_d  = count_q;
    status_d = ST_OK;
    victim_d = '0;
    key_we   = 1'b0;
    case (op_q)
      OP_ADD: begin
        if (hit_any) begin
          status_d = ST_DUPLICATE;
        end else if (!free_any) begin
          status_d = ST_FULL;
        end else begin
          key_we             = 1'b1;
          valid_d[free_idx]  = 1'b1;
          pinned_d[free_idx] = 1'b0;
          rank_d[free_idx]   = count_q[RANK_W-1:0];
          count_d            = count_q + CNT_W'(1);
        end
      end
      OP_ACCESS: begin
        if (!hit_any) begin
          status_d = ST_NOT_FOUND;
        end else if (!pinned_q[hit_idx]) begin
          rank_d          = rank_dec;
          rank_d[hit_idx] = RANK_W'(count_q - CNT_W'(1));
        end
      end
      OP_POP: begin
        if (!lru_any) begin
          status_d = ST_EMPTY;
        end else begin
          victim_d         = key_q[lru_idx];
          rank_d           = rank_dec;
          rank_d[lru_idx]  = '0;
          valid_d[lru_idx] = 1'b0;
          count_d          = count_q - CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!hit_any) begin
          status_d = ST_NOT_FOUND;
        end else begin
          if (!pinned_q[hit_idx]) begin
            rank_d  = rank_dec;
            count_d = count_q - CNT_W'(1);
          end
          rank_d[hit_idx]   = '0;
          valid_d[hit_idx]  = 1'b0;
          pinned_d[hit_idx] = 1'b0;
        end
      end
      OP_PIN: begin
        if (!hit_any) begin
          status_d = ST_NOT_FOUND;
        end else if (!pinned_q[hit_idx]) begin
          rank_d            = rank_dec;
          rank_d[hit_idx]   = '0;
          pinned_d[hit_idx] = 1'b1;
          count_d           = count_q - CNT_W'(1);
        end
      end
      OP_UNPIN: begin
        if (!hit_any) begin
          status_d = ST_NOT_FOUND;
        end else if (pinned_q[hit_idx]) begin
          pinned_d[hit_idx] = 1'b0;
          rank_d[hit_idx]   = count_q[RANK_W-1:0];
          count_d           = count_q + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // table state commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      pinned_q <= '0;
      count_q  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (adv) begin
      valid_q  <= valid_d;
      pinned_q <= pinned_d;
      count_q  <= count_d;
      rank_q   <= rank_d;
    end
  end

  // key store, read only where valid
  always_ff @(posedge clk_i) begin
    if (adv && key_we) begin
      key_q[free_idx] <= ikey_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q <= status_d;
      victim_q <= victim_d;
    end
  end

  // count only changes when a new result is loaded
  assign out_o.valid          = out_vld_q;
  assign out_o.status         = status_q;
  assign out_o.victim_key     = victim_q;
  assign out_o.unpinned_count = count_q;
  assign out_o.can_replace    = (count_q != '0);

endmodule

FILE: hdl/lrurp_checker.sv
`timescale 1ns / 1ps

module lrurp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [lrurp_pkg::STATUS_W-1:0] status_i,
  input  logic [lrurp_pkg::KEY_W-1:0]    victim_key_i,
  input  logic                          can_replace_i,
  input  logic [lrurp_pkg::CNT_W-1:0]    unpinned_count_i
);
  import lrurp_pkg::*;

  // unpinned count never exceeds the table size
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (unpinned_count_i <= CNT_W'(ENTRIES)))
    else $error("unpinned count beyond table size");

  // replace flag follows the count
  a_can_replace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (can_replace_i == (unpinned_count_i != '0)))
    else $error("can_replace disagrees with unpinned count");

  // a nonzero victim key only comes with an OK status
  a_victim_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (victim_key_i != '0)) |-> (status_i == ST_OK))
    else $error("victim key reported on a failed item");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(status_i) && $stable(victim_key_i)
       && $stable(unpinned_count_i)))
    else $error("result changed while stalled");

endmodule

bind lru_replacer_with_pinning_unit lrurp_checker u_lrurp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_i         (out_o.status),
  .victim_key_i     (out_o.victim_key),
  .can_replace_i    (out_o.can_replace),
  .unpinned_count_i (out_o.unpinned_count)
);
